[design/slca_pkg.sv]
// ----------------------------------------------------------------------------
// slca_pkg
// Shared types and codes of the sticky least-loaded core assigner.
// ----------------------------------------------------------------------------
package slca_pkg;

  localparam int ID_W = 22;

  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_PROC = 2'd1;
  localparam logic [1:0] KIND_THR  = 2'd2;

  localparam logic [1:0] ROUTE_LOCAL  = 2'd0;
  localparam logic [1:0] ROUTE_FIXED  = 2'd1;
  localparam logic [1:0] ROUTE_ASSIGN = 2'd2;
  localparam logic [1:0] ROUTE_WRITE  = 2'd3;

  localparam logic [1:0] REG_FIXED_MODE = 2'd0;
  localparam logic [1:0] REG_FIXED_CORE = 2'd1;
  localparam logic [1:0] REG_SLICE_MULT = 2'd2;

  localparam logic [30:0] LOAD_MAX = 31'h7fffffff;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] thread_id;
    logic [ID_W-1:0] group_id;
    logic [7:0]      flag_value;
    logic            flag_keep;
  } item_t;

  typedef struct packed {
    logic [1:0]  route;
    logic [1:0]  target_core;
    logic [15:0] slice_scale;
    logic        at_head;
    logic        id_out_of_range;
  } result_t;

  // decoded request handed from front to back
  typedef struct packed {
    item_t item;
    logic  tid_ok;
    logic  gid_ok;
  } job_t;

endpackage

[design/slca_front.sv]
// ----------------------------------------------------------------------------
// slca_front
// Accepts requests, checks ids against the table depth, two-entry queue.
// ----------------------------------------------------------------------------
module slca_front #(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  slca_pkg::item_t    item,
  output logic               job_valid,
  output slca_pkg::job_t     job,
  input  logic               job_take
);

  localparam logic [slca_pkg::ID_W-1:0] DEPTH_L = slca_pkg::ID_W'(TABLE_DEPTH);

  slca_pkg::job_t slots [2];
  logic [1:0]     count;
  logic           wr_ptr;
  logic           rd_ptr;
  slca_pkg::job_t decoded;
  logic           do_push;

  always_comb begin
    decoded.item   = item;
    decoded.tid_ok = item.thread_id < DEPTH_L;
    decoded.gid_ok = item.group_id < DEPTH_L;
  end

  assign full      = count == 2'd2;
  assign do_push   = push && !full;
  assign job_valid = count != 2'd0;
  assign job       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (job_take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(job_take);
    end
  end

endmodule

[design/slca_back.sv]
// ----------------------------------------------------------------------------
// slca_back
// Flag and assignment tables, load counters and the routing sequencer.
// ----------------------------------------------------------------------------
module slca_back #(
  parameter int CORES       = 4,
  parameter int TABLE_DEPTH = 8192
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  slca_pkg::job_t      job,
  output logic                job_take,
  input  logic                room,
  input  logic                fixed_mode,
  input  logic [1:0]          fixed_core,
  input  logic [15:0]         slice_mult,
  output logic                res_valid,
  output slca_pkg::result_t   res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(CORES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] LAST_CORE = CW'(CORES - 1);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EVAL, ST_SCAN} state_t;

  state_t          state;
  logic [AW-1:0]   clr_addr;
  slca_pkg::job_t  cur;
  logic            prio_r;
  logic [CW-1:0]   scan_idx;
  logic [CW-1:0]   best;
  logic [30:0]     best_load;
  logic [30:0]     load [CORES];

  logic [8:0]      pmem [TABLE_DEPTH];
  logic [8:0]      tmem [TABLE_DEPTH];
  logic [CW:0]     amem [TABLE_DEPTH];
  logic [8:0]      p_rd;
  logic [8:0]      t_rd;
  logic [CW:0]     a_rd;

  logic            p_we;
  logic            t_we;
  logic            a_we;
  logic [AW-1:0]   p_wa;
  logic [AW-1:0]   t_wa;
  logic [8:0]      flag_wd;
  logic [CW:0]     a_wd;

  logic [8:0]      pf;
  logic [8:0]      tf;
  logic            prio;
  logic            nonprio;
  logic            need_scan;
  logic            scan_better;
  logic            scan_last;
  logic [CW-1:0]   pick;
  logic [30:0]     pick_load;

  assign job_take = (state == ST_IDLE) && job_valid && room;

  // table writes: clearing pass, flag writes on take, assignment at scan end
  always_comb begin
    flag_wd = job.item.flag_keep ? {1'b1, job.item.flag_value} : 9'd0;
    p_wa    = job.item.group_id[AW-1:0];
    t_wa    = job.item.thread_id[AW-1:0];
    p_we    = job_take && job.item.kind == slca_pkg::KIND_PROC && job.gid_ok;
    t_we    = job_take && job.item.kind == slca_pkg::KIND_THR && job.tid_ok;
    if (state == ST_CLEAR) begin
      p_we    = 1'b1;
      t_we    = 1'b1;
      p_wa    = clr_addr;
      t_wa    = clr_addr;
      flag_wd = 9'd0;
    end
  end

  assign scan_better = load[scan_idx] <= best_load;
  assign scan_last   = scan_idx == LAST_CORE;
  assign pick        = scan_better ? scan_idx : best;
  assign pick_load   = scan_better ? load[scan_idx] : best_load;

  always_comb begin
    a_we = (state == ST_CLEAR) || (state == ST_SCAN && scan_last);
    a_wd = (state == ST_CLEAR) ? '0 : {1'b1, pick};
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_wa] <= flag_wd;
    end
    p_rd <= pmem[job.item.group_id[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_wa] <= flag_wd;
    end
    t_rd <= tmem[job.item.thread_id[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[(state == ST_CLEAR) ? clr_addr : cur.item.thread_id[AW-1:0]] <= a_wd;
    end
    a_rd <= amem[job.item.thread_id[AW-1:0]];
  end

  // classification of the enqueue from the table reads
  always_comb begin
    pf        = cur.gid_ok ? p_rd : 9'd0;
    tf        = cur.tid_ok ? t_rd : 9'd0;
    prio      = pf == 9'h101 && tf == 9'h101;
    nonprio   = pf == 9'h100 && tf == 9'h100;
    need_scan = cur.item.kind == slca_pkg::KIND_ENQ && (prio || nonprio)
                && !(prio && fixed_mode) && !a_rd[CW];
  end

  always_comb begin
    res_valid           = 1'b0;
    res.route           = slca_pkg::ROUTE_WRITE;
    res.target_core     = 2'd0;
    res.slice_scale     = 16'd1;
    res.at_head         = 1'b0;
    res.id_out_of_range = 1'b0;
    if (state == ST_EVAL) begin
      res_valid = !need_scan;
      case (cur.item.kind)
        slca_pkg::KIND_PROC: res.id_out_of_range = !cur.gid_ok;
        slca_pkg::KIND_THR:  res.id_out_of_range = !cur.tid_ok;
        slca_pkg::KIND_ENQ: begin
          res.id_out_of_range = !(cur.tid_ok && cur.gid_ok);
          if (!prio && !nonprio) begin
            res.route = slca_pkg::ROUTE_LOCAL;
          end else if (prio && fixed_mode) begin
            res.route       = slca_pkg::ROUTE_FIXED;
            res.target_core = fixed_core;
            res.at_head     = 1'b1;
          end else begin
            res.route       = slca_pkg::ROUTE_ASSIGN;
            res.target_core = 2'(a_rd[CW-1:0]);
            res.slice_scale = prio ? slice_mult : 16'd1;
            res.at_head     = prio;
          end
        end
        default: res.id_out_of_range = 1'b0;
      endcase
    end else if (state == ST_SCAN && scan_last) begin
      res_valid           = 1'b1;
      res.route           = slca_pkg::ROUTE_ASSIGN;
      res.target_core     = 2'(pick);
      res.slice_scale     = prio_r ? slice_mult : 16'd1;
      res.at_head         = prio_r;
      res.id_out_of_range = !(cur.tid_ok && cur.gid_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      for (int c = 0; c < CORES; c++) begin
        load[c] <= '0;
      end
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (job_take) begin
            cur   <= job;
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          prio_r    <= prio;
          scan_idx  <= '0;
          best      <= '0;
          best_load <= slca_pkg::LOAD_MAX;
          state     <= need_scan ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          best      <= pick;
          best_load <= pick_load;
          scan_idx  <= scan_idx + CW'(1);
          if (scan_last) begin
            if (pick_load != slca_pkg::LOAD_MAX) begin
              load[pick] <= pick_load + 31'd1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/slca_outq.sv]
// ----------------------------------------------------------------------------
// slca_outq
// Two-entry result queue between the sequencer and the consumer.
// ----------------------------------------------------------------------------
module slca_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  slca_pkg::result_t   res,
  output logic                room,
  output logic                empty,
  input  logic                pop,
  output slca_pkg::result_t   result
);

  slca_pkg::result_t slots [2];
  logic [1:0]        count;
  logic              wr_ptr;
  logic              rd_ptr;
  logic              do_pop;

  assign empty  = count == 2'd0;
  assign room   = count != 2'd2;
  assign do_pop = pop && !empty;
  assign result = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_valid) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (res_valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(res_valid) - 2'(do_pop);
    end
  end

endmodule

[design/sticky_least_loaded_core_assigner_unit.sv]
// ----------------------------------------------------------------------------
// sticky_least_loaded_core_assigner_unit
// Routes task enqueues to cores from process and thread class flags.
// ----------------------------------------------------------------------------
// requests enter through push/full, results leave through empty/pop, both
// as queues; each request gives exactly one result, in order.
// flag writes, other non-enqueue requests and unclassified, fixed-core or
// already assigned enqueues put their result on the ports after a table
// read, then a decision, and the sequencer then returns to idle.
// a thread's first assigned enqueue scans the load counters one core a
// cycle; its result shows when the scan reaches the last core and the next
// request is taken only after that, one request at a time.
// a two-entry request queue and a two-entry result queue let the sides
// stall apart; when pop stays low the result queue fills, the sequencer
// holds, and then full rises once the request queue is full.
// after reset a clearing pass writes every table entry, during which no
// request leaves the request queue; registers reset to fixed_mode 0,
// fixed_core 0, slice_multiplier 1 and may be written then.
// configuration is on an apb port at byte addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module sticky_least_loaded_core_assigner_unit #(
  parameter int CORES       = 4,
  parameter int TABLE_DEPTH = 8192
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  slca_pkg::item_t     item,
  output logic                empty,
  input  logic                pop,
  output slca_pkg::result_t   result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic              fixed_mode;
  logic [1:0]        fixed_core;
  logic [15:0]       slice_mult;
  logic              cfg_wr;
  logic              job_valid;
  slca_pkg::job_t    job;
  logic              job_take;
  logic              room;
  logic              res_valid;
  slca_pkg::result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_mode <= 1'b0;
      fixed_core <= 2'd0;
      slice_mult <= 16'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        slca_pkg::REG_FIXED_MODE: fixed_mode <= pwdata[0];
        slca_pkg::REG_FIXED_CORE: fixed_core <= pwdata[1:0];
        slca_pkg::REG_SLICE_MULT: slice_mult <= pwdata[15:0];
        default: fixed_mode <= fixed_mode;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      slca_pkg::REG_FIXED_MODE: prdata = {31'd0, fixed_mode};
      slca_pkg::REG_FIXED_CORE: prdata = {30'd0, fixed_core};
      slca_pkg::REG_SLICE_MULT: prdata = {16'd0, slice_mult};
      default: prdata = 32'd0;
    endcase
  end

  slca_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  slca_back #(
    .CORES      (CORES),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (job),
    .job_take   (job_take),
    .room       (room),
    .fixed_mode (fixed_mode),
    .fixed_core (fixed_core),
    .slice_mult (slice_mult),
    .res_valid  (res_valid),
    .res        (res)
  );

  slca_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

[tb/sv/sticky_least_loaded_core_assigner_unit_chk.sv]
// ----------------------------------------------------------------------------
// sticky_least_loaded_core_assigner_unit_chk
// Watches the request and result queues of the core assigner, predicts each
// routing decision from its own copy of the flag tables, the sticky core
// assignments and the load counters, and compares every result in order.
// ----------------------------------------------------------------------------
module sticky_least_loaded_core_assigner_unit_chk #(
  parameter int CORES       = 4,
  parameter int TABLE_DEPTH = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  slca_pkg::item_t   item,
  input  logic              empty,
  input  logic              pop,
  input  slca_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                fails,
  output int                pending,
  output int                n_results,
  output int                n_prio
);

  logic [8:0]        proc_flag [TABLE_DEPTH];
  logic [8:0]        thr_flag [TABLE_DEPTH];
  logic [2:0]        sticky_core [TABLE_DEPTH];
  logic [30:0]       load [CORES];
  logic              fixed_mode_q;
  logic [1:0]        fixed_core_q;
  logic [15:0]       slice_mult_q;
  slca_pkg::result_t route_q [$];

  assign pending = route_q.size();

  function automatic int pick_least_loaded();
    int best;
    logic [30:0] best_load;
    best = 0;
    best_load = slca_pkg::LOAD_MAX;
    for (int c = 0; c < CORES; c++) begin
      if (load[c] <= best_load) begin
        best = c;
        best_load = load[c];
      end
    end
    return best;
  endfunction

  task automatic route_request(input slca_pkg::item_t it);
    slca_pkg::result_t r;
    logic tid_ok, gid_ok, prio, nonprio;
    logic [8:0] pf, tf;
    int core;
    tid_ok = it.thread_id < TABLE_DEPTH;
    gid_ok = it.group_id < TABLE_DEPTH;
    r = '{route: slca_pkg::ROUTE_WRITE, target_core: 2'd0, slice_scale: 16'd1,
          at_head: 1'b0, id_out_of_range: 1'b0};
    if (it.kind == slca_pkg::KIND_PROC || it.kind == slca_pkg::KIND_THR) begin
      if (it.kind == slca_pkg::KIND_PROC) begin
        if (gid_ok) proc_flag[it.group_id] = it.flag_keep ? {1'b1, it.flag_value} : 9'd0;
        r.id_out_of_range = !gid_ok;
      end else begin
        if (tid_ok) thr_flag[it.thread_id] = it.flag_keep ? {1'b1, it.flag_value} : 9'd0;
        r.id_out_of_range = !tid_ok;
      end
    end else if (it.kind == slca_pkg::KIND_ENQ) begin
      r.id_out_of_range = !(tid_ok && gid_ok);
      pf = gid_ok ? proc_flag[it.group_id] : 9'd0;
      tf = tid_ok ? thr_flag[it.thread_id] : 9'd0;
      prio = pf == 9'h101 && tf == 9'h101;
      nonprio = pf == 9'h100 && tf == 9'h100;
      if (!prio && !nonprio) begin
        r.route = slca_pkg::ROUTE_LOCAL;
      end else if (prio && fixed_mode_q) begin
        r.route = slca_pkg::ROUTE_FIXED;
        r.target_core = fixed_core_q;
        r.at_head = 1'b1;
      end else begin
        if (sticky_core[it.thread_id][2]) begin
          core = int'(sticky_core[it.thread_id][1:0]);
        end else begin
          core = pick_least_loaded();
          sticky_core[it.thread_id] = {1'b1, 2'(core)};
          if (load[core] < slca_pkg::LOAD_MAX) load[core] = load[core] + 31'd1;
        end
        r.route = slca_pkg::ROUTE_ASSIGN;
        r.target_core = 2'(core);
        if (prio) begin
          r.slice_scale = slice_mult_q;
          r.at_head = 1'b1;
        end
      end
      if (prio) n_prio++;
    end
    route_q.push_back(r);
  endtask

  always @(posedge clk) begin
    slca_pkg::result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        proc_flag[i] = '0;
        thr_flag[i] = '0;
        sticky_core[i] = '0;
      end
      for (int c = 0; c < CORES; c++) load[c] = '0;
      fixed_mode_q = 1'b0;
      fixed_core_q = 2'd0;
      slice_mult_q = 16'd1;
      route_q.delete();
      fails = 0;
      n_results = 0;
      n_prio = 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          slca_pkg::REG_FIXED_MODE: fixed_mode_q = pwdata[0];
          slca_pkg::REG_FIXED_CORE: fixed_core_q = pwdata[1:0];
          slca_pkg::REG_SLICE_MULT: slice_mult_q = pwdata[15:0];
          default: ;
        endcase
      end
      if (!empty && pop) begin
        n_results++;
        if (route_q.size() == 0) begin
          $error("result with no request outstanding: %p", result);
          fails++;
        end else begin
          want = route_q.pop_front();
          if (result.route !== want.route) begin
            $error("route: expected %0d, got %0d", want.route, result.route);
            fails++;
          end
          if (result.target_core !== want.target_core) begin
            $error("target_core: expected %0d, got %0d", want.target_core, result.target_core);
            fails++;
          end
          if (result.slice_scale !== want.slice_scale) begin
            $error("slice_scale: expected %0d, got %0d", want.slice_scale, result.slice_scale);
            fails++;
          end
          if (result.at_head !== want.at_head) begin
            $error("at_head: expected %0d, got %0d", want.at_head, result.at_head);
            fails++;
          end
          if (result.id_out_of_range !== want.id_out_of_range) begin
            $error("id_out_of_range: expected %0d, got %0d",
                   want.id_out_of_range, result.id_out_of_range);
            fails++;
          end
        end
      end
      // request accepted after the pop so the queue order holds
      if (push && !full) route_request(item);
    end
  end

endmodule

[tb/sv/sticky_least_loaded_core_assigner_unit_tb.sv]
// ----------------------------------------------------------------------------
// sticky_least_loaded_core_assigner_unit_tb
// Drives flag writes and enqueues through the request queue with random
// stalls on both sides, reconfigures the routing registers between phases,
// and lets the checker compare every routing result.
// ----------------------------------------------------------------------------
module sticky_least_loaded_core_assigner_unit_tb;

  localparam int CORES       = 4;
  localparam int TABLE_DEPTH = 8192;
  localparam int WATCH_LIMIT = 3 * TABLE_DEPTH + 2000;

  logic              clk, rst, push, full, empty, pop, psel, penable, pwrite, pready;
  slca_pkg::item_t   item;
  slca_pkg::result_t result;
  logic [3:0]        paddr;
  logic [31:0]       pwdata, prdata;
  int                fails, pending, n_results, n_prio, n_sent, idle_cycles;
  logic              stalls_on;

  sticky_least_loaded_core_assigner_unit #(.CORES(CORES), .TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sticky_least_loaded_core_assigner_unit_chk #(.CORES(CORES), .TABLE_DEPTH(TABLE_DEPTH)) chk (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .fails, .pending, .n_results, .n_prio
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: pop with random stall bursts
  initial begin
    int gap;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_on && !rst && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 18);
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send(input slca_pkg::item_t it);
    int gap;
    if (stalls_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 18);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    n_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  function automatic slca_pkg::item_t mk(input logic [1:0] k, input logic [21:0] tid,
                                         input logic [21:0] gid, input logic [7:0] fv,
                                         input logic keep);
    return '{kind: k, thread_id: tid, group_id: gid, flag_value: fv, flag_keep: keep};
  endfunction

  // ids mostly in a small pool so flags and assignments get reused
  function automatic logic [21:0] pick_id();
    case ($urandom_range(0, 19))
      0: return 22'($urandom);
      1: return 22'(TABLE_DEPTH - 1 - $urandom_range(0, 3));
      2: return 22'(TABLE_DEPTH + $urandom_range(0, 3));
      default: return 22'($urandom_range(0, 63));
    endcase
  endfunction

  // write flags for a pair then enqueue it, occasionally broken
  task automatic random_task();
    logic [21:0] tid, gid;
    logic [7:0] fv;
    int r;
    tid = pick_id();
    gid = pick_id();
    fv = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 1));
    r = $urandom_range(0, 9);
    if (r < 5) begin
      send(mk(slca_pkg::KIND_PROC, 22'($urandom), gid, fv, $urandom_range(0, 7) != 0));
      send(mk(slca_pkg::KIND_THR, tid, 22'($urandom), $urandom_range(0, 4) == 0 ? ~fv : fv,
              $urandom_range(0, 7) != 0));
      send(mk(slca_pkg::KIND_ENQ, tid, gid, 8'($urandom), 1'($urandom)));
    end else if (r < 8) begin
      send(mk(slca_pkg::KIND_ENQ, tid, gid, 8'($urandom), 1'($urandom)));
    end else begin
      send(mk(2'($urandom), 22'($urandom), 22'($urandom), 8'($urandom), 1'($urandom)));
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0; item = '0; stalls_on = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    n_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: priority, non-priority, unclassified, out of range, kind 3
    send(mk(slca_pkg::KIND_PROC, 22'd0, 22'd5, 8'd1, 1'b1));
    send(mk(slca_pkg::KIND_THR, 22'd5, 22'd0, 8'd1, 1'b1));
    send(mk(slca_pkg::KIND_ENQ, 22'd5, 22'd5, 8'hff, 1'b1));
    send(mk(slca_pkg::KIND_ENQ, 22'd5, 22'd5, 8'h00, 1'b0));
    send(mk(slca_pkg::KIND_PROC, 22'h3fffff, 22'd7, 8'd0, 1'b1));
    send(mk(slca_pkg::KIND_THR, 22'd7, 22'h3fffff, 8'd0, 1'b1));
    send(mk(slca_pkg::KIND_ENQ, 22'd7, 22'd7, 8'd0, 1'b0));
    send(mk(slca_pkg::KIND_THR, 22'd8, 22'd0, 8'hff, 1'b1));
    send(mk(slca_pkg::KIND_ENQ, 22'd8, 22'd7, 8'd0, 1'b0));
    send(mk(slca_pkg::KIND_PROC, 22'd0, 22'(TABLE_DEPTH), 8'd1, 1'b1));
    send(mk(slca_pkg::KIND_THR, 22'(TABLE_DEPTH - 1), 22'd0, 8'd0, 1'b1));
    send(mk(slca_pkg::KIND_PROC, 22'd0, 22'(TABLE_DEPTH - 1), 8'd0, 1'b1));
    send(mk(slca_pkg::KIND_ENQ, 22'(TABLE_DEPTH - 1), 22'(TABLE_DEPTH - 1), 8'd0, 1'b0));
    send(mk(slca_pkg::KIND_ENQ, 22'h3fffff, 22'd7, 8'd0, 1'b0));
    send(mk(slca_pkg::KIND_ENQ, 22'd7, 22'h3fffff, 8'd0, 1'b0));
    send(mk(2'd3, 22'h3fffff, 22'h3fffff, 8'hff, 1'b1));
    // deletion keeps the sticky core
    send(mk(slca_pkg::KIND_THR, 22'd5, 22'd0, 8'd1, 1'b0));
    send(mk(slca_pkg::KIND_ENQ, 22'd5, 22'd5, 8'd0, 1'b0));
    send(mk(slca_pkg::KIND_THR, 22'd5, 22'd0, 8'd1, 1'b1));
    wait_drained();
    write_reg(slca_pkg::REG_FIXED_MODE, 32'd1);
    write_reg(slca_pkg::REG_FIXED_CORE, 32'd3);
    write_reg(slca_pkg::REG_SLICE_MULT, 32'hffff);
    send(mk(slca_pkg::KIND_ENQ, 22'd5, 22'd5, 8'd0, 1'b0));
    wait_drained();
    write_reg(slca_pkg::REG_FIXED_MODE, 32'd0);
    send(mk(slca_pkg::KIND_ENQ, 22'd5, 22'd5, 8'd0, 1'b0));

    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      write_reg(slca_pkg::REG_FIXED_MODE, phase % 2);
      write_reg(slca_pkg::REG_FIXED_CORE, $urandom_range(0, 3));
      write_reg(slca_pkg::REG_SLICE_MULT,
                phase == 2 ? 32'd0 : (phase == 4 ? 32'hffff : $urandom));
      if (phase == 5) stalls_on = 1'b0;
      while (n_sent < 25 + (phase + 1) * 255) random_task();
    end
    wait_drained();

    $display("%0d requests sent, %0d results checked, %0d priority enqueues",
             n_sent, n_results, n_prio);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
design/slca_pkg.sv
design/slca_front.sv
design/slca_back.sv
design/slca_outq.sv
design/sticky_least_loaded_core_assigner_unit.sv
tb/sv/sticky_least_loaded_core_assigner_unit_chk.sv
tb/sv/sticky_least_loaded_core_assigner_unit_tb.sv
